@@ rtl/amgs_pkg.sv @@
`default_nettype none

package amgs_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_FIRST  = 2'd2;
   localparam logic [1:0] OP_NEXT   = 2'd3;

   localparam int NO_EDGE_WEIGHT = 10000;

   localparam int VERTEX_BITS = 4;
   localparam int COUNT_BITS  = 16;
   localparam int CSR_BITS    = 5;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } amgs_mem_ctl_type;

endpackage

`default_nettype wire

@@ rtl/amgs_matrix.sv @@
`default_nettype none

module amgs_matrix import amgs_pkg::*; #(
   parameter int INDEX_BITS  = 4,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire amgs_mem_ctl_type             ctl,
   input  wire logic [2*INDEX_BITS-1:0]      addr,
   input  wire logic [WEIGHT_BITS-1:0]       wdata,
   output logic      [WEIGHT_BITS-1:0]       rdata,
   output logic                              busy
);

   localparam int ADDR_BITS = 2 * INDEX_BITS;
   localparam int DEPTH     = 1 << ADDR_BITS;

   logic [WEIGHT_BITS-1:0] weight_mem [DEPTH];
   logic [WEIGHT_BITS-1:0] rdata_ff;
   logic                   clearing_ff;
   logic                   clearing_in;
   logic [ADDR_BITS-1:0]   clr_addr_ff;
   logic [ADDR_BITS-1:0]   clr_addr_in;
   logic [WEIGHT_BITS-1:0] init_word;

   // diagonal clears to zero, the rest to the no-edge weight
   always_comb begin
      if (clr_addr_ff[ADDR_BITS-1:INDEX_BITS] == clr_addr_ff[INDEX_BITS-1:0]) begin
         init_word = '0;
      end else begin
         init_word = WEIGHT_BITS'(NO_EDGE_WEIGHT);
      end
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_BITS'(1);
         if (&clr_addr_ff) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         weight_mem[clr_addr_ff] <= init_word;
      end else if (ctl.wr_en) begin
         weight_mem[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= weight_mem[addr];
      end
   end

   assign rdata = rdata_ff;
   assign busy  = clearing_ff;

endmodule

`default_nettype wire

@@ rtl/adjacency_matrix_graph_store_top.sv @@
`default_nettype none
// edits: an accepted request passes the execute state, which writes the matrix, then the
// finish state, which loads the response register; a neighbour query goes from execute to
// a scan state that reads the row's columns in order until a hit or the last active column
// throughput: one word at a time; the next request is taken only after the response register
// loads and the block is back in idle; finish waits while the response output is held off
// reset: no request word is taken while a pass clears all 2**(2*clog2(MAX_VERTICES)) entries (256 by default)

module adjacency_matrix_graph_store_top import amgs_pkg::*; #(
   parameter int MAX_VERTICES = 16,
   parameter int WEIGHT_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [CSR_BITS-1:0]           csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [VERTEX_BITS-1:0]        req_from_vertex,
   input  wire logic [VERTEX_BITS-1:0]        req_to_vertex,
   input  wire logic signed [15:0]            req_weight,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [VERTEX_BITS-1:0]             rsp_neighbor,
   output logic                               rsp_found,
   output logic                               rsp_range_error,
   output logic signed [COUNT_BITS-1:0]       rsp_edge_count
);

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int CW = (IW + 1 > CSR_BITS) ? IW + 1 : CSR_BITS;
   localparam longint W_HI = (64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1;
   localparam longint W_LO = -W_HI - 64'sd1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [CSR_BITS-1:0]           num_vertices_ff;
   logic [1:0]                    op_ff, op_in;
   logic [VERTEX_BITS-1:0]        from_ff, from_in;
   logic [VERTEX_BITS-1:0]        to_ff, to_in;
   logic signed [15:0]            weight_ff, weight_in;
   logic [CW-1:0]                 col_ff, col_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic [CW-1:0]                 rd_col_ff, rd_col_in;
   logic signed [COUNT_BITS-1:0]  count_ff, count_in;
   logic [VERTEX_BITS-1:0]        res_nb_ff, res_nb_in;
   logic                          res_found_ff, res_found_in;
   logic                          res_err_ff, res_err_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_BITS-1:0]        rsp_nb_ff, rsp_nb_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic                          rsp_err_ff, rsp_err_in;
   logic signed [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;

   logic [CW-1:0]                 n_active;
   logic                          from_ok;
   logic                          to_ok;
   logic                          op_err;
   logic                          out_free;
   logic                          hit;
   longint                        w_ext;
   logic [WEIGHT_BITS-1:0]        w_clamped;
   amgs_mem_ctl_type              mem_ctl;
   logic [2*IW-1:0]               mem_addr;
   logic [WEIGHT_BITS-1:0]        mem_wdata;
   logic signed [WEIGHT_BITS-1:0] mem_rdata;
   logic                          mem_busy;

   amgs_matrix #(
      .INDEX_BITS (IW),
      .WEIGHT_BITS(WEIGHT_BITS)
   ) u_matrix (
      .clock(clock),
      .reset(reset),
      .ctl  (mem_ctl),
      .addr (mem_addr),
      .wdata(mem_wdata),
      .rdata(mem_rdata),
      .busy (mem_busy)
   );

   always_comb begin
      if (CW'(num_vertices_ff) > CW'(MAX_VERTICES)) begin
         n_active = CW'(MAX_VERTICES);
      end else begin
         n_active = CW'(num_vertices_ff);
      end
      from_ok = CW'(from_ff) < n_active;
      to_ok   = CW'(to_ff) < n_active;
      if (op_ff == OP_FIRST) begin
         op_err = !from_ok;
      end else begin
         op_err = !(from_ok && to_ok);
      end
      w_ext = longint'(weight_ff);
      if (w_ext > W_HI) begin
         w_clamped = WEIGHT_BITS'(W_HI);
      end else if (w_ext < W_LO) begin
         w_clamped = WEIGHT_BITS'(W_LO);
      end else begin
         w_clamped = WEIGHT_BITS'(w_ext);
      end
      hit      = (mem_rdata > 0) && (mem_rdata < NO_EDGE_WEIGHT);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   assign req_ready = (state_ff == ST_IDLE) && !mem_busy;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      weight_in     = weight_ff;
      col_in        = col_ff;
      rd_valid_in   = 1'b0;
      rd_col_in     = rd_col_ff;
      count_in      = count_ff;
      res_nb_in     = res_nb_ff;
      res_found_in  = res_found_ff;
      res_err_in    = res_err_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_nb_in     = rsp_nb_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_count_in  = rsp_count_ff;
      mem_ctl.wr_en = 1'b0;
      mem_ctl.rd_en = 1'b0;
      mem_addr      = {IW'(from_ff), IW'(to_ff)};
      mem_wdata     = w_clamped;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               op_in     = req_opcode;
               from_in   = req_from_vertex;
               to_in     = req_to_vertex;
               weight_in = req_weight;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_nb_in    = '0;
            res_found_in = 1'b0;
            res_err_in   = op_err;
            state_in     = ST_FINISH;
            if (!op_err) begin
               case (op_ff)
                  OP_INSERT: begin
                     mem_ctl.wr_en = 1'b1;
                     if (count_ff != 16'sh7fff) begin
                        count_in = count_ff + 16'sd1;
                     end
                  end
                  OP_DELETE: begin
                     mem_ctl.wr_en = 1'b1;
                     mem_wdata     = WEIGHT_BITS'(NO_EDGE_WEIGHT);
                     if (count_ff != 16'sh8000) begin
                        count_in = count_ff - 16'sd1;
                     end
                  end
                  OP_FIRST: begin
                     col_in   = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     col_in   = CW'(to_ff) + CW'(1);
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            mem_addr = {IW'(from_ff), col_ff[IW-1:0]};
            if (rd_valid_ff && hit) begin
               res_nb_in    = VERTEX_BITS'(rd_col_ff);
               res_found_in = 1'b1;
               state_in     = ST_FINISH;
            end else if (col_ff < n_active) begin
               mem_ctl.rd_en = 1'b1;
               rd_valid_in   = 1'b1;
               rd_col_in     = col_ff;
               col_in        = col_ff + CW'(1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         default: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_nb_in    = res_nb_ff;
               rsp_found_in = res_found_ff;
               rsp_err_in   = res_err_ff;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         num_vertices_ff <= '0;
         rd_valid_ff     <= 1'b0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            num_vertices_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      from_ff      <= from_in;
      to_ff        <= to_in;
      weight_ff    <= weight_in;
      col_ff       <= col_in;
      rd_col_ff    <= rd_col_in;
      res_nb_ff    <= res_nb_in;
      res_found_ff <= res_found_in;
      res_err_ff   <= res_err_in;
      rsp_nb_ff    <= rsp_nb_in;
      rsp_found_ff <= rsp_found_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_neighbor    = rsp_nb_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_range_error = rsp_err_ff;
   assign rsp_edge_count  = rsp_count_ff;

   a_no_accept_while_clearing : assert property (@(posedge clock) disable iff (reset)
      mem_busy |-> !req_ready)
      else $error("request taken during clearing pass");

   a_read_only_in_scan : assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SCAN))
      else $error("read in flight outside scan");

   a_found_not_error : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> !rsp_err_ff)
      else $error("neighbour found on a range error");

   a_count_only_on_exec : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> ($past(state_ff) == ST_EXEC))
      else $error("edge counter moved outside execution");

endmodule

`default_nettype wire

@@ verif/graph_store_checker.sv @@
module graph_store_checker import amgs_pkg::*; #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_BITS-1:0]    csr_wr_data,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [1:0]             req_opcode,
   input  logic [VERTEX_BITS-1:0] req_from_vertex,
   input  logic [VERTEX_BITS-1:0] req_to_vertex,
   input  logic signed [15:0]     req_weight,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [VERTEX_BITS-1:0] rsp_neighbor,
   input  logic                   rsp_found,
   input  logic                   rsp_range_error,
   input  logic signed [15:0]     rsp_edge_count,
   output int                     mismatches,
   output int                     awaiting
);

   typedef struct packed {
      logic [VERTEX_BITS-1:0] neighbor;
      logic                   found;
      logic                   range_error;
      logic signed [15:0]     edge_count;
   } graph_rsp_type;

   logic signed [15:0]  weights [MAX_VERTICES][MAX_VERTICES];
   logic signed [15:0]  edge_total;
   logic [CSR_BITS-1:0] vertex_count;
   graph_rsp_type       graph_rsp_q [$];
   logic                field_bad;

   initial begin
      mismatches = 0;
      awaiting   = 0;
   end

   function automatic graph_rsp_type apply_graph_op(
      input logic [1:0]             op,
      input logic [VERTEX_BITS-1:0] row,
      input logic [VERTEX_BITS-1:0] col,
      input logic signed [15:0]     w
   );
      graph_rsp_type r;
      int n;
      int start;
      int c;
      n = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
      r = '0;
      if (row >= n || (op != OP_FIRST && col >= n)) begin
         r.range_error = 1'b1;
      end else if (op == OP_INSERT) begin
         weights[row][col] = w;
         if (edge_total != 16'sh7fff) edge_total = edge_total + 16'sd1;
      end else if (op == OP_DELETE) begin
         weights[row][col] = 16'(NO_EDGE_WEIGHT);
         if (edge_total != 16'sh8000) edge_total = edge_total - 16'sd1;
      end else begin
         start = (op == OP_NEXT) ? int'(col) + 1 : 0;
         for (c = start; c < n; c++) begin
            if (!r.found && weights[row][c] > 0 && weights[row][c] < NO_EDGE_WEIGHT) begin
               r.found    = 1'b1;
               r.neighbor = c[VERTEX_BITS-1:0];
            end
         end
      end
      r.edge_count = edge_total;
      return r;
   endfunction

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         field_bad = 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch
      graph_rsp_type want;
      int i;
      int j;
      if (reset) begin
         for (i = 0; i < MAX_VERTICES; i++)
            for (j = 0; j < MAX_VERTICES; j++)
               weights[i][j] = (i == j) ? 16'sd0 : 16'(NO_EDGE_WEIGHT);
         edge_total   = '0;
         vertex_count = '0;
         graph_rsp_q.delete();
      end else begin
         if (csr_wr_en) vertex_count = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (graph_rsp_q.size() == 0) begin
               $display("%0t: unexpected response word, nothing expected, actual %0d/%0d/%0d/%0d",
                        $time, rsp_neighbor, rsp_found, rsp_range_error, rsp_edge_count);
               mismatches++;
            end else begin
               want      = graph_rsp_q.pop_front();
               field_bad = 1'b0;
               check_field("neighbor", want.neighbor, rsp_neighbor);
               check_field("found", want.found, rsp_found);
               check_field("range_error", want.range_error, rsp_range_error);
               check_field("edge_count", int'(want.edge_count), int'(rsp_edge_count));
               if (field_bad) mismatches++;
            end
         end
         if (req_valid && req_ready)
            graph_rsp_q.push_back(apply_graph_op(req_opcode, req_from_vertex,
                                                 req_to_vertex, req_weight));
      end
      awaiting = graph_rsp_q.size();
   end

endmodule

@@ verif/testbench.sv @@
module testbench import amgs_pkg::*;;

   localparam int VERTEX_LIMIT   = 16;
   localparam int SETTLE_CYCLES  = 25;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_BITS-1:0]    csr_wr_data;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_opcode;
   logic [VERTEX_BITS-1:0] req_from_vertex;
   logic [VERTEX_BITS-1:0] req_to_vertex;
   logic signed [15:0]     req_weight;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [VERTEX_BITS-1:0] rsp_neighbor;
   logic                   rsp_found;
   logic                   rsp_range_error;
   logic signed [15:0]     rsp_edge_count;

   int                     mismatches;
   int                     awaiting;
   int                     send_idle_pct;
   int                     recv_stall_pct;
   int                     quiet_cycles;
   int                     words_sent;
   logic                   long_hold_req;
   logic [CSR_BITS-1:0]    current_count;

   adjacency_matrix_graph_store_top #(
      .MAX_VERTICES (VERTEX_LIMIT),
      .WEIGHT_BITS  (16)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .req_weight      (req_weight),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_neighbor    (rsp_neighbor),
      .rsp_found       (rsp_found),
      .rsp_range_error (rsp_range_error),
      .rsp_edge_count  (rsp_edge_count)
   );

   graph_store_checker #(
      .MAX_VERTICES (VERTEX_LIMIT)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .req_weight      (req_weight),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_neighbor    (rsp_neighbor),
      .rsp_found       (rsp_found),
      .rsp_range_error (rsp_range_error),
      .rsp_edge_count  (rsp_edge_count),
      .mismatches      (mismatches),
      .awaiting        (awaiting)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response side: random back-pressure, or one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready     = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [VERTEX_BITS-1:0] row,
                            input logic [VERTEX_BITS-1:0] col, input logic signed [15:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_opcode      = op;
      req_from_vertex = row;
      req_to_vertex   = col;
      req_weight      = w;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_random_word();
      int n;
      int pick;
      logic [1:0] op;
      logic [VERTEX_BITS-1:0] row;
      logic [VERTEX_BITS-1:0] col;
      logic signed [15:0] w;
      n    = (current_count > VERTEX_LIMIT) ? VERTEX_LIMIT : int'(current_count);
      pick = $urandom_range(99);
      op   = (pick < 35) ? OP_INSERT : (pick < 50) ? OP_DELETE :
             (pick < 75) ? OP_FIRST : OP_NEXT;
      row  = (n > 0 && $urandom_range(9) != 0) ? VERTEX_BITS'($urandom_range(n - 1)) :
                                                 VERTEX_BITS'($urandom_range(15));
      col  = (n > 0 && $urandom_range(9) != 0) ? VERTEX_BITS'($urandom_range(n - 1)) :
                                                 VERTEX_BITS'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 40)      w = 16'($urandom_range(9999, 1));
      else if (pick < 55) w = 16'(NO_EDGE_WEIGHT);
      else if (pick < 65) w = 0;
      else if (pick < 75) w = 16'(-$urandom_range(32768, 1));
      else                w = 16'($urandom_range(65535));
      send_word(op, row, col, w);
   endtask

   // wait for every outstanding word, then let any scan finish
   task automatic settle();
      req_valid = 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_vertex_count(input logic [CSR_BITS-1:0] v);
      settle();
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en     = 1'b0;
      current_count = v;
   endtask

   task automatic run_phase(input int words, input logic [CSR_BITS-1:0] v,
                            input int idle_pct, input int stall_pct);
      set_vertex_count(v);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (words) send_random_word();
   endtask

   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_valid       = 1'b0;
      req_opcode      = OP_INSERT;
      req_from_vertex = '0;
      req_to_vertex   = '0;
      req_weight      = '0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      quiet_cycles    = 0;
      words_sent      = 0;
      long_hold_req   = 1'b0;
      current_count   = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // no vertices configured yet, everything out of range
      send_word(OP_INSERT, 0, 0, 1);
      send_word(OP_FIRST, 15, 0, 0);

      set_vertex_count(16);
      send_word(OP_INSERT, 0, 15, 1);
      send_word(OP_INSERT, 0, 3, 9999);
      send_word(OP_INSERT, 0, 5, 10000);
      send_word(OP_INSERT, 0, 7, -32768);
      send_word(OP_INSERT, 15, 0, 32767);
      send_word(OP_INSERT, 3, 3, 5);
      send_word(OP_INSERT, 0, 0, 0);
      send_word(OP_FIRST, 0, 9, 0);
      send_word(OP_NEXT, 0, 3, 0);
      send_word(OP_NEXT, 0, 15, 0);
      send_word(OP_NEXT, 0, 0, 0);
      send_word(OP_FIRST, 15, 0, 0);
      send_word(OP_FIRST, 3, 0, 0);
      send_word(OP_DELETE, 0, 3, 0);
      send_word(OP_FIRST, 0, 0, 0);
      send_word(OP_DELETE, 0, 3, 0);

      // count above capacity behaves as full size
      set_vertex_count(31);
      send_word(OP_FIRST, 0, 0, 0);

      // shrunk count, matrix kept
      set_vertex_count(4);
      send_word(OP_NEXT, 0, 3, 0);
      send_word(OP_FIRST, 0, 0, 0);
      send_word(OP_INSERT, 4, 0, 7);
      send_word(OP_INSERT, 0, 4, 7);
      send_word(OP_NEXT, 0, 4, 0);
      send_word(OP_FIRST, 4, 0, 0);

      // long response stall while words keep coming
      run_phase(60, 16, 0, 0);
      long_hold_req = 1'b1;
      repeat (40) send_random_word();
      settle();
      repeat (100) send_random_word();

      run_phase(200, 16, 66, 0);
      run_phase(200, CSR_BITS'($urandom_range(2, 15)), 0, 66);
      run_phase(200, 16, 14, 14);
      run_phase(150, 31, 0, 0);
      run_phase(50, 0, 66, 66);
      run_phase(100, 1, 0, 0);
      run_phase(150, CSR_BITS'($urandom_range(2, 15)), 14, 14);

      settle();
      $display("run covered %0d request words over vertex counts 0 to 31, all four operations",
               words_sent);
      $display("idle, stall and long hold-off mixes, with the input held off by a full block");
      if (mismatches == 0 && awaiting == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
